// ===== src/dll_pkg.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list manager package
// Shared request and result types, field widths, codes and index wrapping.
// ----------------------------------------------------------------------------
package dll_pkg;

    localparam int NODE_SLOTS_DEF = 256;
    localparam int LIST_COUNT_DEF = 16;

    localparam int MODE_W    = 2;
    localparam int LIST_ID_W = 4;
    localparam int NODE_W    = 8;
    localparam int COUNT_W   = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int QUEUE_DEPTH = 2;

    localparam int RECIP_SHIFT = 16;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PREPEND,
        MODE_APPEND,
        MODE_INSERT,
        MODE_REMOVE
    } t_mode;

    typedef struct packed {
        t_mode                mode;
        logic [LIST_ID_W-1:0] list_id;
        logic [NODE_W-1:0]    node;
        logic [NODE_W-1:0]    target;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] new_count;
        logic               list_now_empty;
        logic [NODE_W-1:0]  new_head;
        logic [NODE_W-1:0]  new_tail;
    } t_result;

    // Remainder of an 8-bit value by a fixed modulus. The quotient comes from a
    // multiplication by the rounded-up reciprocal of the modulus, scaled by
    // 2^RECIP_SHIFT, which is exact for every 8-bit value.
    function automatic logic [NODE_W-1:0] wrap_index(input logic [NODE_W-1:0] value,
                                                     input int unsigned modulus,
                                                     input int unsigned recip);
        logic [24:0]       prod;
        logic [NODE_W-1:0] quot;
        logic [24:0]       rem;
        prod = 25'(value) * 25'(recip);
        quot = prod[RECIP_SHIFT +: NODE_W];
        rem  = 25'(value) - 25'(quot) * 25'(modulus);
        return rem[NODE_W-1:0];
    endfunction

endpackage

// ===== src/doubly_linked_list_manager.sv =====
// A request is taken only while the back end is idle, and a new one only after the
// last has finished, set by the back end's single read and single write port on
// each link memory (one read, then two writes).
// Reset is synchronous and active low: every list becomes empty with a zero
// count and both queues are flushed; the node link memories are not cleared.
// ----------------------------------------------------------------------------
// Doubly linked list manager
// Several doubly linked lists over a shared pool of indexed node slots, with
// a request queue in front and a result queue behind the execution unit.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager #(
    parameter int NODE_SLOTS = dll_pkg::NODE_SLOTS_DEF,
    parameter int LIST_COUNT = dll_pkg::LIST_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [dll_pkg::MODE_W-1:0]    i_mode,
    input  logic [dll_pkg::LIST_ID_W-1:0] i_list_id,
    input  logic [dll_pkg::NODE_W-1:0]    i_node,
    input  logic [dll_pkg::NODE_W-1:0]    i_target,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_status,
    output logic [dll_pkg::COUNT_W-1:0]   o_new_count,
    output logic                          o_list_now_empty,
    output logic [dll_pkg::NODE_W-1:0]    o_new_head,
    output logic [dll_pkg::NODE_W-1:0]    o_new_tail
);

    logic                                w_req_valid;
    dll_pkg::t_req                       w_req;
    logic                                w_req_take;
    logic                                w_res_full;
    logic                                w_res_push;
    dll_pkg::t_result                    w_res;
    dll_pkg::t_result                    w_out;
    logic [$bits(dll_pkg::t_result)-1:0] w_res_bits;
    logic [$bits(dll_pkg::t_result)-1:0] w_out_bits;

    dll_front #(
        .NODE_SLOTS(NODE_SLOTS),
        .LIST_COUNT(LIST_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_mode     (i_mode),
        .i_list_id  (i_list_id),
        .i_node     (i_node),
        .i_target   (i_target),
        .o_req_valid(w_req_valid),
        .o_req      (w_req),
        .i_req_take (w_req_take)
    );

    dll_back #(
        .NODE_SLOTS(NODE_SLOTS),
        .LIST_COUNT(LIST_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(w_req_valid),
        .i_req      (w_req),
        .o_req_take (w_req_take),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    assign w_res_bits = w_res;
    assign w_out      = dll_pkg::t_result'(w_out_bits);

    dll_queue #(
        .WIDTH($bits(dll_pkg::t_result))
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_bits),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_out_bits),
        .o_empty(empty)
    );

    assign o_status         = w_out.status;
    assign o_new_count      = w_out.new_count;
    assign o_list_now_empty = w_out.list_now_empty;
    assign o_new_head       = w_out.new_head;
    assign o_new_tail       = w_out.new_tail;

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("Result produced while the result queue was full.");

    a_take_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_take |-> ##2 w_res_push)
        else $error("A taken request did not produce its result two cycles later.");

    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && (w_res.status == dll_pkg::STATUS_EMPTY)) |-> w_res.list_now_empty)
        else $error("A rejected transaction reported a non-empty list.");

endmodule

// ===== src/dll_queue.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list manager queue
// Two-entry first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module dll_queue #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(dll_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] r_data [dll_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (PTR_W + 1)'(dll_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_data[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PTR_W + 1)'(w_push) - (PTR_W + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/dll_front.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list manager front end
// Accepts requests, wraps list and node indexes, and queues them for the
// execution back end.
// ----------------------------------------------------------------------------
module dll_front #(
    parameter int NODE_SLOTS = dll_pkg::NODE_SLOTS_DEF,
    parameter int LIST_COUNT = dll_pkg::LIST_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [dll_pkg::MODE_W-1:0]     i_mode,
    input  logic [dll_pkg::LIST_ID_W-1:0]  i_list_id,
    input  logic [dll_pkg::NODE_W-1:0]     i_node,
    input  logic [dll_pkg::NODE_W-1:0]     i_target,
    output logic                           o_req_valid,
    output dll_pkg::t_req                  o_req,
    input  logic                           i_req_take
);

    localparam int unsigned NODE_RECIP =
        ((1 << dll_pkg::RECIP_SHIFT) + NODE_SLOTS - 1) / NODE_SLOTS;
    localparam int unsigned LIST_RECIP =
        ((1 << dll_pkg::RECIP_SHIFT) + LIST_COUNT - 1) / LIST_COUNT;

    dll_pkg::t_req                 w_req;
    logic [$bits(dll_pkg::t_req)-1:0] w_in_bits;
    logic [$bits(dll_pkg::t_req)-1:0] w_out_bits;
    logic                          w_empty;

    always_comb begin
        w_req.mode    = dll_pkg::t_mode'(i_mode);
        w_req.list_id = dll_pkg::LIST_ID_W'(
            dll_pkg::wrap_index(dll_pkg::NODE_W'(i_list_id), LIST_COUNT, LIST_RECIP));
        w_req.node    = dll_pkg::wrap_index(i_node, NODE_SLOTS, NODE_RECIP);
        w_req.target  = dll_pkg::wrap_index(i_target, NODE_SLOTS, NODE_RECIP);
    end

    assign w_in_bits   = w_req;
    assign o_req       = dll_pkg::t_req'(w_out_bits);
    assign o_req_valid = !w_empty;

    dll_queue #(
        .WIDTH($bits(dll_pkg::t_req))
    ) u_req_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data (w_in_bits),
        .o_full (o_full),
        .i_pop  (i_req_take),
        .o_data (w_out_bits),
        .o_empty(w_empty)
    );

endmodule

// ===== src/dll_back.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list manager back end
// Executes one request as a link read, an own-link write, and a neighbor
// link write with list table update and result.
// ----------------------------------------------------------------------------
module dll_back #(
    parameter int NODE_SLOTS = dll_pkg::NODE_SLOTS_DEF,
    parameter int LIST_COUNT = dll_pkg::LIST_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  dll_pkg::t_req    i_req,
    output logic             o_req_take,
    input  logic             i_res_full,
    output logic             o_res_push,
    output dll_pkg::t_result o_res
);

    localparam int NW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;

    typedef struct packed {
        logic          is_null;
        logic [NW-1:0] idx;
    } t_link;

    typedef struct packed {
        logic          en;
        logic [NW-1:0] addr;
        t_link         data;
    } t_link_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK,
        ST_NEIGHBOR
    } t_state;

    function automatic t_link_wr link_wr(input logic [NW-1:0] addr, input logic is_null,
                                         input logic [NW-1:0] idx);
        t_link_wr wr;
        wr.en           = 1'b1;
        wr.addr         = addr;
        wr.data.is_null = is_null;
        wr.data.idx     = idx;
        return wr;
    endfunction

    t_state        r_state;
    dll_pkg::t_req r_req;
    t_link         r_next_mem [NODE_SLOTS];
    t_link         r_prev_mem [NODE_SLOTS];
    t_link         r_rd_next;
    t_link         r_rd_prev;

    logic [NW-1:0]               r_head  [LIST_COUNT];
    logic [NW-1:0]               r_tail  [LIST_COUNT];
    logic                        r_empty [LIST_COUNT];
    logic [dll_pkg::COUNT_W-1:0] r_count [LIST_COUNT];

    logic                        w_take;
    logic [NW-1:0]               w_rd_addr;
    logic [LW-1:0]               w_l;
    logic [NW-1:0]               w_n;
    logic [NW-1:0]               w_tg;
    logic [NW-1:0]               w_head;
    logic [NW-1:0]               w_tail;
    logic                        w_empty;
    logic [dll_pkg::COUNT_W-1:0] w_count;
    logic [dll_pkg::COUNT_W-1:0] w_count_up;
    logic [dll_pkg::COUNT_W-1:0] w_count_down;

    t_link_wr                    w_own_next;
    t_link_wr                    w_own_prev;
    t_link_wr                    w_nb_next;
    t_link_wr                    w_nb_prev;
    t_link_wr                    w_next_wr;
    t_link_wr                    w_prev_wr;

    logic                        w_status;
    logic [NW-1:0]               w_new_head;
    logic [NW-1:0]               w_new_tail;
    logic                        w_new_empty;
    logic [dll_pkg::COUNT_W-1:0] w_new_count;
    logic                        w_update;

    assign w_take     = (r_state == ST_IDLE) && i_req_valid && !i_res_full;
    assign o_req_take = w_take;
    assign w_rd_addr  = (i_req.mode == dll_pkg::MODE_INSERT) ? NW'(i_req.target)
                                                             : NW'(i_req.node);

    assign w_l     = LW'(r_req.list_id);
    assign w_n     = NW'(r_req.node);
    assign w_tg    = NW'(r_req.target);
    assign w_head  = r_head[w_l];
    assign w_tail  = r_tail[w_l];
    assign w_empty = r_empty[w_l];
    assign w_count = r_count[w_l];

    assign w_count_up   = (w_count == dll_pkg::COUNT_MAX) ? w_count : w_count + 1'b1;
    assign w_count_down = (w_count == '0) ? w_count : w_count - 1'b1;

    always_comb begin
        w_own_next  = '0;
        w_own_prev  = '0;
        w_nb_next   = '0;
        w_nb_prev   = '0;
        w_status    = dll_pkg::STATUS_DONE;
        w_new_head  = w_head;
        w_new_tail  = w_tail;
        w_new_empty = w_empty;
        w_new_count = w_count;
        case (r_req.mode)
            dll_pkg::MODE_PREPEND, dll_pkg::MODE_APPEND: begin
                w_new_count = w_count_up;
                if (w_empty) begin
                    w_new_head  = w_n;
                    w_new_tail  = w_n;
                    w_new_empty = 1'b0;
                    w_own_next  = link_wr(w_n, 1'b1, '0);
                    w_own_prev  = link_wr(w_n, 1'b1, '0);
                end else if (r_req.mode == dll_pkg::MODE_PREPEND) begin
                    w_new_head = w_n;
                    w_own_next = link_wr(w_n, 1'b0, w_head);
                    w_own_prev = link_wr(w_n, 1'b1, '0);
                    w_nb_prev  = link_wr(w_head, 1'b0, w_n);
                end else begin
                    w_new_tail = w_n;
                    w_own_prev = link_wr(w_n, 1'b0, w_tail);
                    w_own_next = link_wr(w_n, 1'b1, '0);
                    w_nb_next  = link_wr(w_tail, 1'b0, w_n);
                end
            end
            dll_pkg::MODE_INSERT: begin
                if (w_empty) begin
                    w_status = dll_pkg::STATUS_EMPTY;
                end else if (w_tg == w_tail) begin
                    w_new_count = w_count_up;
                    w_new_tail  = w_n;
                    w_own_prev  = link_wr(w_n, 1'b0, w_tail);
                    w_own_next  = link_wr(w_n, 1'b1, '0);
                    w_nb_next   = link_wr(w_tail, 1'b0, w_n);
                end else begin
                    w_new_count = w_count_up;
                    w_own_prev  = link_wr(w_n, 1'b0, w_tg);
                    w_own_next  = link_wr(w_n, r_rd_next.is_null, r_rd_next.idx);
                    if (!r_rd_next.is_null) begin
                        w_nb_prev = link_wr(r_rd_next.idx, 1'b0, w_n);
                    end
                    w_nb_next = link_wr(w_tg, 1'b0, w_n);
                end
            end
            dll_pkg::MODE_REMOVE: begin
                if (w_empty) begin
                    w_status = dll_pkg::STATUS_EMPTY;
                end else begin
                    w_new_count = w_count_down;
                    if (w_head == w_tail) begin
                        w_new_head  = '0;
                        w_new_tail  = '0;
                        w_new_empty = 1'b1;
                    end else if (w_n == w_head) begin
                        w_new_head = r_rd_next.idx;
                        w_own_prev = link_wr(r_rd_next.idx, 1'b1, '0);
                    end else if (w_n == w_tail) begin
                        w_new_tail = r_rd_prev.idx;
                        w_own_next = link_wr(r_rd_prev.idx, 1'b1, '0);
                    end else begin
                        if (!r_rd_prev.is_null) begin
                            w_own_next = link_wr(r_rd_prev.idx, r_rd_next.is_null,
                                                 r_rd_next.idx);
                        end
                        if (!r_rd_next.is_null) begin
                            w_own_prev = link_wr(r_rd_next.idx, r_rd_prev.is_null,
                                                 r_rd_prev.idx);
                        end
                    end
                end
            end
            default: begin
                w_status = dll_pkg::STATUS_DONE;
            end
        endcase
    end

    always_comb begin
        w_next_wr = '0;
        w_prev_wr = '0;
        if (r_state == ST_LINK) begin
            w_next_wr = w_own_next;
            w_prev_wr = w_own_prev;
        end else if (r_state == ST_NEIGHBOR) begin
            w_next_wr = w_nb_next;
            w_prev_wr = w_nb_prev;
        end
    end

    assign w_update   = (r_state == ST_NEIGHBOR);
    assign o_res_push = w_update;

    always_comb begin
        o_res.status         = w_status;
        o_res.new_count      = w_new_count;
        o_res.list_now_empty = w_new_empty;
        o_res.new_head       = w_new_empty ? '0 : dll_pkg::NODE_W'(w_new_head);
        o_res.new_tail       = w_new_empty ? '0 : dll_pkg::NODE_W'(w_new_tail);
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= i_req;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_state <= ST_LINK;
                    end
                end
                ST_LINK: begin
                    r_state <= ST_NEIGHBOR;
                end
                ST_NEIGHBOR: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_next_wr.en) begin
            r_next_mem[w_next_wr.addr] <= w_next_wr.data;
        end
        if (w_prev_wr.en) begin
            r_prev_mem[w_prev_wr.addr] <= w_prev_wr.data;
        end
        if (w_take) begin
            r_rd_next <= r_next_mem[w_rd_addr];
            r_rd_prev <= r_prev_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIST_COUNT; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_empty[i] <= 1'b1;
                r_count[i] <= '0;
            end
        end else if (w_update) begin
            r_head[w_l]  <= w_new_head;
            r_tail[w_l]  <= w_new_tail;
            r_empty[w_l] <= w_new_empty;
            r_count[w_l] <= w_new_count;
        end
    end

endmodule
